[src/set_assoc_lru_cache_sim_assert.svh]
// Assertion helpers for the cache model block.
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset.
`define SALC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define SALC_ASSERT(lbl, prop, msg) \
    `SALC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[src/salc_pkg.sv]
package salc_pkg;

    localparam int MAX_SETS = 16;
    localparam int MAX_WAYS = 4;

    localparam int ADDR_W = 64;
    localparam int TAG_W  = 64;
    localparam int CNT_W  = 32;
    localparam int CMD_W  = 2;
    localparam int OUTC_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SETB_W = 3;
    localparam int OFFB_W = 6;
    localparam int WAYS_W = 3;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    // largest k with 2^k <= MAX_SETS
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam logic [SETB_W-1:0] SB_LIM = (SB_MAX >= 7) ? 3'd7 : SETB_W'(SB_MAX);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(MAX_WAYS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_FETCH  = 2'd3
    } t_cmd;

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // one RAM row holds a whole set
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

[src/salc_req_if.sv]
interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::CMD_W-1:0]  command;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

[src/salc_rsp_if.sv]
interface salc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::OUTC_W-1:0] outcome;
    logic                        second_hit;
    logic [salc_pkg::CNT_W-1:0]  hit_total;
    logic [salc_pkg::CNT_W-1:0]  miss_total;
    logic [salc_pkg::CNT_W-1:0]  eviction_total;

    modport source (output valid, outcome, second_hit, hit_total, miss_total,
                    eviction_total, input ready);
    modport sink   (input valid, outcome, second_hit, hit_total, miss_total,
                    eviction_total, output ready);
endinterface

[src/set_assoc_lru_cache_sim.sv]
// Channel   Dir  Beat payload
// i_req     in   command, address
// o_rsp     out  outcome, second_hit, hit_total, miss_total, eviction_total
//
// Instruction fetch: taken while idle, no beat out.
// Load/store/modify: split and set row read, one way per
//   cycle through the shared tag compare, then row write-back and result.
// Modify's second access is folded into the write-back cycle.
// Valid bits sit in flops cleared by reset; no clearing pass.
// Write-back waits while the previous result beat is still unaccepted.
`include "set_assoc_lru_cache_sim_assert.svh"

module set_assoc_lru_cache_sim (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    salc_req_if.sink                            i_req,
    salc_rsp_if.source                          o_rsp
);
    localparam int SET_W  = salc_pkg::SET_W;
    localparam int WAY_W  = salc_pkg::WAY_W;
    localparam int RANK_W = salc_pkg::RANK_W;
    localparam int NWAYS  = salc_pkg::MAX_WAYS;

    salc_pkg::t_state r_state, n_state;

    logic [salc_pkg::SETB_W-1:0] r_set_bits;
    logic [salc_pkg::OFFB_W-1:0] r_offset_bits;
    logic [salc_pkg::WAYS_W-1:0] r_ways;

    salc_pkg::t_cmd               r_cmd;
    logic [salc_pkg::ADDR_W-1:0]  r_addr;
    logic [SET_W-1:0]             r_set;
    logic [salc_pkg::TAG_W-1:0]   r_tag;
    logic [WAY_W-1:0]             r_way;
    logic                         r_hit;
    logic [WAY_W-1:0]             r_hit_way;
    logic                         r_empty;
    logic [WAY_W-1:0]             r_empty_way;
    logic [WAY_W-1:0]             r_vict_way;
    logic [RANK_W-1:0]            r_best;

    logic [salc_pkg::MAX_SETS-1:0][NWAYS-1:0] r_valid;
    logic [salc_pkg::CNT_W-1:0]   r_hits, r_misses, r_evicts;

    logic                         r_out_valid;
    salc_pkg::t_outcome           r_out_outcome;
    logic                         r_out_second;

    logic                         w_accept;
    logic                         w_ram_re;
    logic                         w_commit;
    logic [salc_pkg::SETB_W-1:0]  w_sb;
    logic [SET_W-1:0]             w_set_mask;
    logic [salc_pkg::ADDR_W-1:0]  w_addr_sh;
    logic [SET_W-1:0]             w_set;
    logic [salc_pkg::TAG_W-1:0]   w_tag;
    logic [WAY_W:0]               w_ways_eff;
    logic                         w_in_use;
    logic                         w_cur_valid;
    logic [RANK_W-1:0]            w_cur_rank;
    logic [salc_pkg::ROW_W-1:0]   w_ram_rdata;
    salc_pkg::t_row               w_row, w_new_row;
    logic [NWAYS-1:0][RANK_W-1:0] w_rank;
    logic [WAY_W-1:0]             w_tgt_way;
    logic [RANK_W-1:0]            w_limit;
    logic                         w_fill;
    logic                         w_second;
    logic [1:0]                   w_hit_inc;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_offset_bits <= '0;
            r_ways        <= salc_pkg::WAYS_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                salc_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[salc_pkg::SETB_W-1:0];
                salc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[salc_pkg::OFFB_W-1:0];
                salc_pkg::CFG_WAYS_IN_USE: r_ways        <= i_cfg_data[salc_pkg::WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- address split ----
    always_comb begin
        w_sb       = (r_set_bits > salc_pkg::SB_LIM) ? salc_pkg::SB_LIM : r_set_bits;
        w_set_mask = ~({SET_W{1'b1}} << w_sb);
        w_addr_sh  = r_addr >> r_offset_bits;
        w_set      = w_addr_sh[SET_W-1:0] & w_set_mask;
        // shifts of 64 or more give zero, which is the wide-split tag
        w_tag      = w_addr_sh >> w_sb;
        if (r_ways == '0) begin
            w_ways_eff = (WAY_W + 1)'(1);
        end else if (32'(r_ways) > 32'(NWAYS)) begin
            w_ways_eff = (WAY_W + 1)'(NWAYS);
        end else begin
            w_ways_eff = (WAY_W + 1)'(r_ways);
        end
    end

    // ---- set row storage ----
    salc_ram #(
        .DATA_W (salc_pkg::ROW_W),
        .DEPTH  (salc_pkg::MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit),
        .i_waddr (r_set),
        .i_wdata (w_new_row),
        .i_re    (w_ram_re),
        .i_raddr (w_set),
        .o_rdata (w_ram_rdata)
    );

    assign w_row = w_ram_rdata;

    // invalid lines read as rank 0
    always_comb begin
        for (int j = 0; j < NWAYS; j++) begin
            w_rank[j] = r_valid[r_set][j] ? w_row.rank[j] : '0;
        end
    end

    // ---- shared way compare ----
    assign w_in_use    = ({1'b0, r_way} < w_ways_eff);
    assign w_cur_valid = r_valid[r_set][r_way];
    assign w_cur_rank  = w_rank[r_way];

    // ---- write-back row ----
    always_comb begin
        w_tgt_way = r_hit ? r_hit_way : (r_empty ? r_empty_way : r_vict_way);
        w_limit   = r_hit ? w_rank[r_hit_way] : r_best;
        w_fill    = !r_hit && r_empty;
        w_new_row = w_row;
        for (int j = 0; j < NWAYS; j++) begin
            if (WAY_W'(j) == w_tgt_way) begin
                w_new_row.rank[j] = '0;
                if (!r_hit) begin
                    w_new_row.tag[j] = r_tag;
                end
            end else if (r_valid[r_set][j] && (w_fill || w_rank[j] < w_limit)) begin
                w_new_row.rank[j] = w_rank[j] + RANK_W'(1);
            end else begin
                w_new_row.rank[j] = w_rank[j];
            end
        end
        // second access of a modify always hits the line just touched
        w_second  = (r_cmd == salc_pkg::CMD_MODIFY);
        w_hit_inc = {1'b0, r_hit} + {1'b0, w_second};
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_ram_re = 1'b0;
        w_accept = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            salc_pkg::ST_IDLE: begin
                w_accept = i_req.valid;
                if (i_req.valid && i_req.command != salc_pkg::CMD_FETCH) begin
                    n_state = salc_pkg::ST_SPLIT;
                end
            end
            salc_pkg::ST_SPLIT: begin
                w_ram_re = 1'b1;
                n_state  = salc_pkg::ST_SCAN;
            end
            salc_pkg::ST_SCAN: begin
                if (r_way == salc_pkg::LAST_WAY) begin
                    n_state = salc_pkg::ST_UPDATE;
                end
            end
            salc_pkg::ST_UPDATE: begin
                w_commit = !r_out_valid || o_rsp.ready;
                if (w_commit) begin
                    n_state = salc_pkg::ST_IDLE;
                end
            end
            default: n_state = salc_pkg::ST_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == salc_pkg::ST_IDLE);

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= salc_pkg::t_cmd'(i_req.command);
            r_addr <= i_req.address;
        end
        if (r_state == salc_pkg::ST_SPLIT) begin
            r_set <= w_set;
            r_tag <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_hit_way   <= '0;
            r_empty     <= 1'b0;
            r_empty_way <= '0;
            r_vict_way  <= '0;
            r_best      <= '0;
        end else if (r_state == salc_pkg::ST_SPLIT) begin
            r_way      <= '0;
            r_hit      <= 1'b0;
            r_empty    <= 1'b0;
            r_vict_way <= '0;
            r_best     <= '0;
        end else if (r_state == salc_pkg::ST_SCAN) begin
            r_way <= r_way + WAY_W'(1);
            if (w_in_use) begin
                // lowest matching way wins
                if (w_cur_valid && w_row.tag[r_way] == r_tag && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= r_way;
                end
                if (!w_cur_valid && !r_empty) begin
                    r_empty     <= 1'b1;
                    r_empty_way <= r_way;
                end
                // last way with the highest rank is the victim
                if (w_cur_rank >= r_best) begin
                    r_best     <= w_cur_rank;
                    r_vict_way <= r_way;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (w_commit) begin
            r_valid[r_set][w_tgt_way] <= 1'b1;
            r_hits   <= salc_pkg::sat_add(r_hits, w_hit_inc);
            r_misses <= salc_pkg::sat_add(r_misses, {1'b0, !r_hit});
            r_evicts <= salc_pkg::sat_add(r_evicts, {1'b0, !r_hit && !r_empty});
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_second  <= w_second;
            if (r_hit) begin
                r_out_outcome <= salc_pkg::OUT_HIT;
            end else if (r_empty) begin
                r_out_outcome <= salc_pkg::OUT_FILL;
            end else begin
                r_out_outcome <= salc_pkg::OUT_EVICT;
            end
        end
    end

    // totals only move at a commit, which never passes a waiting beat
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.outcome        = r_out_outcome;
    assign o_rsp.second_hit     = r_out_second;
    assign o_rsp.hit_total      = r_hits;
    assign o_rsp.miss_total     = r_misses;
    assign o_rsp.eviction_total = r_evicts;

    `SALC_ASSERT(a_fetch_no_work, (i_req.valid && i_req.ready && i_req.command == salc_pkg::CMD_FETCH) |=> (r_state == salc_pkg::ST_IDLE), "fetch started an access")
    `SALC_ASSERT(a_access_starts, (i_req.valid && i_req.ready && i_req.command != salc_pkg::CMD_FETCH) |=> (r_state == salc_pkg::ST_SPLIT), "access did not start")
    `SALC_ASSERT(a_target_valid, w_commit |=> r_valid[$past(r_set)][$past(w_tgt_way)], "written way not valid")
    `SALC_ASSERT(a_commit_beat, w_commit |=> r_out_valid, "commit without result beat")

endmodule

[src/salc_ram.sv]
module salc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                            i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                            o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
